// ===== rtl/core/rsn_pkg.sv =====
// Shared types, constants, a saturation function and the elaboration-time cosine function of the resonator filter.
`default_nettype none

package rsn_pkg;

	localparam longint unsigned ONE_Q30 = 64'd1073741824;
	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned HALF_PI_Q30 = PI_Q30 / 2;

	// Register indexes of the configuration port
	localparam logic [0:0] CFG_MODE = 1'b0;
	localparam logic [0:0] CFG_GAIN = 1'b1;

	// Filter mode codes
	localparam logic [2:0] MODE_PURE  = 3'd0;
	localparam logic [2:0] MODE_RESON = 3'd1;
	localparam logic [2:0] MODE_PEAK  = 3'd2;
	localparam logic [2:0] MODE_LOW   = 3'd3;
	localparam logic [2:0] MODE_HIGH  = 3'd4;

	localparam logic [15:0] GAIN_RESET = 16'd4096;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_COEF,
		ST_M_RC,
		ST_M_RR,
		ST_M_RX,
		ST_NORM,
		ST_M_A2Y,
		ST_M_NY,
		ST_LOAD_T,
		ST_M_TG,
		ST_OUT
	} rsn_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rsn_fifo_stat_t;

	// Clamp a 40-bit value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] res;
		if (v > 40'sd2147483647) begin
			res = 32'sh7fffffff;
		end else if (v < -40'sd2147483648) begin
			res = 32'sh80000000;
		end else begin
			res = v[31:0];
		end
		return res;
	endfunction

	// Cosine table entry for a Q34.30 angle in [0, 2*pi), folded to a quarter cycle
	function automatic logic signed [31:0] cos_fold(input longint unsigned ang_in);
		longint unsigned a;
		longint unsigned x2;
		longint unsigned term;
		longint c;
		logic neg;
		a = ang_in;
		neg = 1'b0;
		if (a > PI_Q30) begin
			a = 2 * PI_Q30 - a;
		end
		if (a > HALF_PI_Q30) begin
			a = PI_Q30 - a;
			neg = 1'b1;
		end
		x2 = (a * a) >> 30;
		term = ONE_Q30;
		term = ONE_Q30 - ((x2 * term) >> 30) / 240;
		term = ONE_Q30 - ((x2 * term) >> 30) / 182;
		term = ONE_Q30 - ((x2 * term) >> 30) / 132;
		term = ONE_Q30 - ((x2 * term) >> 30) / 90;
		term = ONE_Q30 - ((x2 * term) >> 30) / 56;
		term = ONE_Q30 - ((x2 * term) >> 30) / 30;
		term = ONE_Q30 - ((x2 * term) >> 30) / 12;
		c = longint'(ONE_Q30) - longint'(((x2 * term) >> 30) / 2);
		if (c > longint'(ONE_Q30)) begin
			c = longint'(ONE_Q30);
		end
		if (c < -longint'(ONE_Q30)) begin
			c = -longint'(ONE_Q30);
		end
		if (neg) begin
			c = -c;
		end
		return c[31:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rsn_if.sv =====
// Valid/ready channel interfaces for the resonator sample input and output.
`default_nettype none

interface rsn_in_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;
	logic [15:0]                    centre_freq;
	logic [15:0]                    quality;
	logic                           block_end;

	modport source (output valid, output sample_in, output centre_freq,
		output quality, output block_end, input ready);
	modport sink (input valid, input sample_in, input centre_freq,
		input quality, input block_end, output ready);
endinterface

interface rsn_out_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic                           block_end_out;

	modport source (output valid, output sample_out, output block_end_out, input ready);
	modport sink (input valid, input sample_out, input block_end_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rsn_front.sv =====
// Front end: accepts items, forms pi*f, clamps Q and works out the cosine index.
`default_nettype none

module rsn_front #(
	parameter int COS_TABLE_DEPTH = 1024,
	parameter int SAMPLE_WIDTH    = 16,
	parameter int IDX_W           = $clog2(COS_TABLE_DEPTH),
	parameter int ITEM_W          = SAMPLE_WIDTH + 48 + 16 + IDX_W + 1
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire  [SAMPLE_WIDTH-1:0]     sample_in,
	input  wire  [15:0]                 centre_freq,
	input  wire  [15:0]                 quality,
	input  wire                         block_end,
	output logic                        push,
	output logic [ITEM_W-1:0]           push_data,
	input  rsn_pkg::rsn_fifo_stat_t     fifo_stat
);

	localparam int SH_W = $clog2(COS_TABLE_DEPTH + 1);
	localparam int FD_W = 16 + SH_W;

	logic                    valid_s1;
	logic [SAMPLE_WIDTH-1:0] sample_s1;
	logic [47:0]             num_s1;
	logic [15:0]             q_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    blk_s1;

	logic [FD_W-1:0] fd;
	logic [SH_W-1:0] sh;
	logic [IDX_W-1:0] idx;
	logic [15:0]     q_cl;
	logic            accept;

	// Round f to the table grid, wrap the top entry to zero and clamp Q to at least 256
	always_comb begin
		fd  = FD_W'(centre_freq) * FD_W'(COS_TABLE_DEPTH) + FD_W'(32768);
		sh  = fd[FD_W-1:16];
		idx = (sh == SH_W'(COS_TABLE_DEPTH)) ? '0 : sh[IDX_W-1:0];
		q_cl = (quality < 16'd256) ? 16'd256 : quality;
	end

	assign push     = valid_s1 && !fifo_stat.full;
	assign in_ready = !valid_s1 || !fifo_stat.full;
	assign accept   = in_valid && in_ready;

	// Hold the stage until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample_in;
			num_s1    <= 48'(rsn_pkg::PI_Q30[31:0]) * 48'(centre_freq);
			q_s1      <= q_cl;
			idx_s1    <= idx;
			blk_s1    <= block_end;
		end
	end

	assign push_data = {sample_s1, num_s1, q_s1, idx_s1, blk_s1};

endmodule

`default_nettype wire

// ===== rtl/core/rsn_fifo.sv =====
// Two-entry queue between the front end and the filter engine.
`default_nettype none

module rsn_fifo #(
	parameter int W = 8
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  wire  [W-1:0]             push_data,
	input  wire                      pop,
	output logic [W-1:0]             pop_data,
	output rsn_pkg::rsn_fifo_stat_t  stat
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign pop_data   = mem_q[rd_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rsn_div.sv =====
// Radix-4 restoring divider for pi*f / (256*q), two quotient bits a cycle.
`default_nettype none

module rsn_div (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [47:0] num,
	input  wire  [15:0] quality,
	output logic        done,
	output logic [31:0] quot
);

	logic [23:0] den_q;
	logic [23:0] rem_q;
	logic [31:0] bits_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [24:0] t1;
	logic [24:0] t2;
	logic [23:0] r1;
	logic [23:0] r2;
	logic        ge1;
	logic        ge2;

	// Two compare-and-subtract steps
	always_comb begin
		t1  = {rem_q, bits_q[31]};
		ge1 = (t1 >= {1'b0, den_q});
		r1  = ge1 ? 24'(t1 - {1'b0, den_q}) : t1[23:0];
		t2  = {r1, bits_q[30]};
		ge2 = (t2 >= {1'b0, den_q});
		r2  = ge2 ? 24'(t2 - {1'b0, den_q}) : t2[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift numerator bits out and quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= {quality, 8'd0};
			rem_q  <= {8'd0, num[47:32]};
			bits_q <= num[31:0];
		end else if (busy_q) begin
			rem_q  <= r2;
			bits_q <= {bits_q[29:0], ge1, ge2};
		end
	end

	assign done = done_q;
	assign quot = bits_q;

endmodule

`default_nettype wire

// ===== rtl/core/rsn_back.sv =====
// Filter engine: coefficients, state update and output scaling on one shared multiplier.
`default_nettype none

module rsn_back #(
	parameter int COS_TABLE_DEPTH = 1024,
	parameter int SAMPLE_WIDTH    = 16,
	parameter int IDX_W           = $clog2(COS_TABLE_DEPTH),
	parameter int ITEM_W          = SAMPLE_WIDTH + 48 + 16 + IDX_W + 1
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire  [ITEM_W-1:0]             item,
	input  rsn_pkg::rsn_fifo_stat_t       fifo_stat,
	output logic                          pop,
	input  wire  [2:0]                    mode,
	input  wire  [15:0]                   gain,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] out_sample,
	output logic                          out_blk
);

	localparam int OUT_SH = 37 - SAMPLE_WIDTH;
	localparam int P_W    = 69;
	localparam logic signed [P_W-1:0] SMAX = (P_W'(1) <<< (SAMPLE_WIDTH - 1)) - P_W'(1);
	localparam logic signed [P_W-1:0] SMIN = -SMAX - P_W'(1);
	localparam logic signed [35:0] ONE36 = 36'sd1073741824;

	// Item fields
	logic signed [SAMPLE_WIDTH-1:0] it_sample;
	logic [47:0]      it_num;
	logic [15:0]      it_q;
	logic [IDX_W-1:0] it_idx;
	logic             it_blk;

	assign {it_sample, it_num, it_q, it_idx, it_blk} = item;

	// Cosine ROM
	logic signed [31:0] rom_w [COS_TABLE_DEPTH];

	for (genvar k = 0; k < COS_TABLE_DEPTH; k++) begin : g_rom
		localparam longint unsigned ANG =
			(2 * rsn_pkg::PI_Q30 * longint'(k)) / COS_TABLE_DEPTH;
		assign rom_w[k] = rsn_pkg::cos_fold(ANG);
	end

	// Sample to Q1.24
	logic signed [24:0] x_conv;

	if (SAMPLE_WIDTH <= 25) begin : g_xup
		assign x_conv = 25'(it_sample) <<< (25 - SAMPLE_WIDTH);
	end else begin : g_xdn
		localparam int XSH = SAMPLE_WIDTH - 25;
		logic signed [SAMPLE_WIDTH-1:0] adj;
		assign adj = it_sample + $signed({{(SAMPLE_WIDTH-XSH){1'b0}},
			{XSH{it_sample[SAMPLE_WIDTH-1]}}});
		assign x_conv = 25'(adj >>> XSH);
	end

	rsn_pkg::rsn_state_t state_q;
	rsn_pkg::rsn_state_t state_d;

	logic               div_done;
	logic [31:0]        quot;
	logic               mul_en;
	logic               mul_out_sh;
	logic signed [35:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [P_W-1:0] p_q;
	logic               sh_out_q;
	logic signed [P_W-1:0] res;
	logic signed [P_W-1:0] adj30;
	logic signed [P_W-1:0] adjo;

	logic signed [24:0] x_q;
	logic signed [31:0] cs_q;
	logic               blk_q;
	logic [30:0]        r_q;
	logic signed [32:0] y_q;
	logic signed [32:0] a1_q;
	logic [30:0]        a2_q;
	logic signed [32:0] norm_q;
	logic signed [32:0] c2x_q;
	logic signed [35:0] t_q;
	logic signed [31:0] delay_one_q;
	logic signed [31:0] delay_two_q;
	logic               out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
	logic               out_blk_q;

	logic [2:0]         mode_e;
	logic signed [32:0] x33;
	logic signed [32:0] a2_33;
	logic signed [35:0] a1_36;
	logic signed [35:0] a2_36;
	logic signed [35:0] v3;
	logic signed [35:0] v4;
	logic signed [35:0] norm_d;
	logic signed [32:0] c2x_d;
	logic signed [39:0] c1x;
	logic signed [39:0] h1;
	logic signed [39:0] h2;
	logic signed [SAMPLE_WIDTH-1:0] o_sat;
	logic               out_load;

	rsn_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (pop),
		.num     (it_num),
		.quality (it_q),
		.done    (div_done),
		.quot    (quot)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rsn_pkg::ST_IDLE:   if (!fifo_stat.empty) state_d = rsn_pkg::ST_DIV;
			rsn_pkg::ST_DIV:    if (div_done) state_d = rsn_pkg::ST_COEF;
			rsn_pkg::ST_COEF:   state_d = rsn_pkg::ST_M_RC;
			rsn_pkg::ST_M_RC:   state_d = rsn_pkg::ST_M_RR;
			rsn_pkg::ST_M_RR:   state_d = rsn_pkg::ST_M_RX;
			rsn_pkg::ST_M_RX:   state_d = rsn_pkg::ST_NORM;
			rsn_pkg::ST_NORM:   state_d = rsn_pkg::ST_M_A2Y;
			rsn_pkg::ST_M_A2Y:  state_d = rsn_pkg::ST_M_NY;
			rsn_pkg::ST_M_NY:   state_d = rsn_pkg::ST_LOAD_T;
			rsn_pkg::ST_LOAD_T: state_d = rsn_pkg::ST_M_TG;
			rsn_pkg::ST_M_TG:   state_d = rsn_pkg::ST_OUT;
			rsn_pkg::ST_OUT:    if (out_load) state_d = rsn_pkg::ST_IDLE;
			default:            state_d = rsn_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: queue pop and multiplier operands
	always_comb begin
		pop        = 1'b0;
		mul_en     = 1'b0;
		mul_out_sh = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		case (state_q)
			rsn_pkg::ST_IDLE: pop = !fifo_stat.empty;
			rsn_pkg::ST_M_RC: begin
				mul_en = 1'b1;
				mul_a  = $signed({5'd0, r_q});
				mul_b  = 33'(cs_q);
			end
			rsn_pkg::ST_M_RR: begin
				mul_en = 1'b1;
				mul_a  = $signed({5'd0, r_q});
				mul_b  = $signed({2'd0, r_q});
			end
			rsn_pkg::ST_M_RX: begin
				mul_en = 1'b1;
				mul_a  = $signed({5'd0, r_q});
				mul_b  = x33;
			end
			rsn_pkg::ST_NORM: begin
				mul_en = 1'b1;
				mul_a  = 36'(y_q);
				mul_b  = a1_q;
			end
			rsn_pkg::ST_M_A2Y: begin
				mul_en = 1'b1;
				mul_a  = 36'(y_q);
				mul_b  = a2_33;
			end
			rsn_pkg::ST_M_NY: begin
				mul_en = 1'b1;
				mul_a  = 36'(y_q);
				mul_b  = norm_q;
			end
			rsn_pkg::ST_M_TG: begin
				mul_en     = 1'b1;
				mul_out_sh = 1'b1;
				mul_a      = t_q;
				mul_b      = 33'($signed(gain));
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// Truncate the registered product toward zero
	always_comb begin
		adj30 = p_q + $signed({{(P_W-30){1'b0}}, {30{p_q[P_W-1]}}});
		adjo  = p_q + $signed({{(P_W-OUT_SH){1'b0}}, {OUT_SH{p_q[P_W-1]}}});
		res   = sh_out_q ? (adjo >>> OUT_SH) : (adj30 >>> 30);
	end

	// Mode terms, normalisation, state sums and output saturation
	always_comb begin
		mode_e = (mode > rsn_pkg::MODE_HIGH) ? rsn_pkg::MODE_PURE : mode;
		x33    = 33'(x_q);
		a2_33  = $signed({2'd0, a2_q});
		a1_36  = 36'(a1_q);
		a2_36  = 36'(a2_33);
		v3     = ONE36 + a1_36 + a2_36;
		v4     = ONE36 - a1_36 + a2_36;
		case (mode_e)
			rsn_pkg::MODE_RESON: begin
				norm_d = ONE36 - $signed({5'd0, r_q});
				c2x_d  = -33'(res[32:0]);
			end
			rsn_pkg::MODE_PEAK: begin
				norm_d = (ONE36 - a2_36) >>> 1;
				c2x_d  = -x33;
			end
			rsn_pkg::MODE_LOW: begin
				norm_d = (v3 + $signed({34'd0, {2{v3[35]}}})) >>> 2;
				c2x_d  = x33;
			end
			rsn_pkg::MODE_HIGH: begin
				norm_d = (v4 + $signed({35'd0, v4[35]})) >>> 1;
				c2x_d  = x33;
			end
			default: begin
				norm_d = ONE36;
				c2x_d  = '0;
			end
		endcase
		if (mode_e == rsn_pkg::MODE_LOW) begin
			c1x = 40'(x_q) <<< 1;
		end else if (mode_e == rsn_pkg::MODE_HIGH) begin
			c1x = -(40'(x_q) <<< 1);
		end else begin
			c1x = '0;
		end
		h1 = c1x - res[39:0] + 40'(delay_two_q);
		h2 = 40'(c2x_q) - res[39:0];
		if (res > SMAX) begin
			o_sat = SMAX[SAMPLE_WIDTH-1:0];
		end else if (res < SMIN) begin
			o_sat = SMIN[SAMPLE_WIDTH-1:0];
		end else begin
			o_sat = res[SAMPLE_WIDTH-1:0];
		end
	end

	assign out_load = (state_q == rsn_pkg::ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rsn_pkg::ST_IDLE;
			delay_one_q <= '0;
			delay_two_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rsn_pkg::ST_M_A2Y) begin
				delay_one_q <= rsn_pkg::sat32(h1);
			end
			if (state_q == rsn_pkg::ST_M_NY) begin
				delay_two_q <= rsn_pkg::sat32(h2);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (mul_en) begin
			p_q      <= mul_a * mul_b;
			sh_out_q <= mul_out_sh;
		end
		if (pop) begin
			x_q   <= x_conv;
			cs_q  <= rom_w[it_idx];
			blk_q <= it_blk;
		end
		case (state_q)
			rsn_pkg::ST_COEF: begin
				r_q <= (quot >= 32'd1073741824) ? '0 : 31'(32'd1073741824 - quot);
			end
			rsn_pkg::ST_M_RC: y_q  <= 33'(x_q) + 33'(delay_one_q);
			rsn_pkg::ST_M_RR: a1_q <= -$signed({res[31:0], 1'b0});
			rsn_pkg::ST_M_RX: a2_q <= res[30:0];
			rsn_pkg::ST_NORM: begin
				norm_q <= norm_d[32:0];
				c2x_q  <= c2x_d;
			end
			rsn_pkg::ST_LOAD_T: t_q <= res[35:0];
			default: begin
			end
		endcase
		if (out_load) begin
			out_sample_q <= o_sat;
			out_blk_q    <= blk_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_blk    = out_blk_q;

endmodule

`default_nettype wire

// ===== rtl/core/two_pole_resonator_filter.sv =====
// Top level of the two-pole resonator filter.
// Usage:
//   in_ch carries one audio sample with its centre frequency, Q and block end
//   mark; an item is taken when valid and ready are both high. out_ch returns
//   one filtered, gain-scaled, saturated sample per input item, in order,
//   with the block end mark copied.
//   cfg_we/cfg_index/cfg_data write filter_mode (index 0) and output_gain
//   (index 1); the user writes only while the block is idle (not enforced).
// Data flow:
//   An accepted item passes through one front stage and the queue to the
//   engine, which runs a radix-4 divide, then seven passes through the shared
//   multiplier, before it loads the output register. The engine takes one
//   item at a time and pops no new item before the last is through. The front
//   stage and a two-entry queue take up to three further items meanwhile.
// Reset:
//   arst_n clears both filter state words to zero, sets mode to pure and the
//   gain to 1.0, and empties the queue and output register.
// Back-pressure:
//   a finished sample waits in the output register; the engine stalls only
//   when its next result is ready and the register is still full.
`default_nettype none

module two_pole_resonator_filter #(
	parameter int COS_TABLE_DEPTH = 1024,
	parameter int SAMPLE_WIDTH    = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [0:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	rsn_in_if.sink      in_ch,
	rsn_out_if.source   out_ch
);

	localparam int IDX_W  = $clog2(COS_TABLE_DEPTH);
	localparam int ITEM_W = SAMPLE_WIDTH + 48 + 16 + IDX_W + 1;

	logic [2:0]  mode_q;
	logic [15:0] gain_q;

	logic                    push;
	logic [ITEM_W-1:0]       push_data;
	logic                    pop;
	logic [ITEM_W-1:0]       pop_data;
	rsn_pkg::rsn_fifo_stat_t fifo_stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rsn_pkg::MODE_PURE;
			gain_q <= rsn_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rsn_pkg::CFG_MODE: mode_q <= cfg_data[2:0];
				rsn_pkg::CFG_GAIN: gain_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rsn_front #(
		.COS_TABLE_DEPTH (COS_TABLE_DEPTH),
		.SAMPLE_WIDTH    (SAMPLE_WIDTH),
		.IDX_W           (IDX_W),
		.ITEM_W          (ITEM_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.sample_in   (in_ch.sample_in),
		.centre_freq (in_ch.centre_freq),
		.quality     (in_ch.quality),
		.block_end   (in_ch.block_end),
		.push        (push),
		.push_data   (push_data),
		.fifo_stat   (fifo_stat)
	);

	rsn_fifo #(
		.W (ITEM_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (fifo_stat)
	);

	rsn_back #(
		.COS_TABLE_DEPTH (COS_TABLE_DEPTH),
		.SAMPLE_WIDTH    (SAMPLE_WIDTH),
		.IDX_W           (IDX_W),
		.ITEM_W          (ITEM_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (pop_data),
		.fifo_stat  (fifo_stat),
		.pop        (pop),
		.mode       (mode_q),
		.gain       (gain_q),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_sample (out_ch.sample_out),
		.out_blk    (out_ch.block_end_out)
	);

endmodule

`default_nettype wire

// ===== rtl/core/rsn_checker.sv =====
// Port-level checks of the resonator filter, bound to the top level.
`default_nettype none

module rsn_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    in_valid,
	input wire                    in_ready,
	input wire                    out_valid,
	input wire                    out_ready,
	input wire [SAMPLE_WIDTH-1:0] out_sample,
	input wire                    out_blk
);

	logic [2:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Track items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_sample) && $stable(out_blk))
		else $error("output item changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("output item without a pending input item");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd5)
		else $error("more items in flight than the block can hold");

endmodule

bind two_pole_resonator_filter rsn_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_rsn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_sample (out_ch.sample_out),
	.out_blk    (out_ch.block_end_out)
);

`default_nettype wire
